@@ rtl/gme_pkg.sv @@
// Shared types and constants for the gradient map evaluator.
// Used by gme_cell, gme_mix and gradient_map_evaluate_top; no dependencies.
package gme_pkg;

  localparam int MAX_STOPS  = 16;
  localparam int COORD_BITS = 16;
  localparam int SLOT_W     = $clog2(MAX_STOPS);
  localparam int CNT_W      = $clog2(MAX_STOPS + 1);

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;
  localparam logic [1:0] MODE_CUBIC  = 2'd3;

  localparam logic CFG_INTERP_MODE  = 1'b0;
  localparam logic CFG_ACTIVE_STOPS = 1'b1;

  localparam logic REQ_EVAL  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef logic [3:0][15:0] rgba_t;  // [0] red .. [3] alpha

  typedef struct packed {
    logic        req_type;
    logic [3:0]  stop_slot;
    logic [15:0] coord;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
  } in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } out_t;

  // search record that travels down the row of cells
  typedef struct packed {
    logic                  vld;
    logic [COORD_BITS-1:0] x;
    logic                  lv;
    logic [COORD_BITS-1:0] lpos;
    rgba_t                 lcol;
    logic                  rv;
    logic [COORD_BITS-1:0] rpos;
    rgba_t                 rcol;
  } rec_t;

  typedef struct packed {
    logic                  en;
    logic [3:0]            slot;
    logic [COORD_BITS-1:0] pos;
    rgba_t                 col;
  } wr_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } mix_stat_t;

  // Q30 coefficients of the sine series, alternating signs applied by the caller
  function automatic logic [30:0] sin_coef(input logic [2:0] k);
    logic [30:0] c;
    case (k)
      3'd0:    c = 31'd1686629713;
      3'd1:    c = 31'd693598684;
      3'd2:    c = 31'd85569306;
      3'd3:    c = 31'd5026999;
      3'd4:    c = 31'd172272;
      3'd5:    c = 31'd3864;
      default: c = 31'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/gme_cell.sv @@
// One stop cell: holds a position and color, refines the passing search record.
// Depends on gme_pkg.
module gme_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gme_pkg::SLOT_W-1:0] cell_idx,
  input  logic [gme_pkg::CNT_W-1:0]  cnt,
  input  gme_pkg::wr_t              wr,
  input  gme_pkg::rec_t             rec_in,
  output gme_pkg::rec_t             rec_out
);

  logic [gme_pkg::COORD_BITS-1:0] pos;
  gme_pkg::rgba_t                 col;
  gme_pkg::rec_t                  rec_q;
  gme_pkg::rec_t                  nxt;
  logic                           en;
  logic                           take_l;
  logic                           take_r;

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.slot) == 32'(cell_idx))) begin
      pos <= wr.pos;
      col <= wr.col;
    end
  end

  always_comb begin
    en     = 32'(cell_idx) < 32'(cnt);
    // strict compare keeps the lower index on ties
    take_l = en && (pos <= rec_in.x) && (!rec_in.lv || (pos > rec_in.lpos));
    take_r = en && (pos >= rec_in.x) && (!rec_in.rv || (pos < rec_in.rpos));
    nxt    = rec_in;
    if (take_l) begin
      nxt.lv   = 1'b1;
      nxt.lpos = pos;
      nxt.lcol = col;
    end
    if (take_r) begin
      nxt.rv   = 1'b1;
      nxt.rpos = pos;
      nxt.rcol = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_q.vld <= 1'b0;
    end else begin
      rec_q <= nxt;
    end
  end

  assign rec_out = rec_q;

endmodule

@@ rtl/gme_mix.sv @@
// Color mixer: picks the single-stop cases, else weights per channel (divides in linear mode).
// Shares one multiplier and one radix-2 divider. Depends on gme_pkg.
module gme_mix (
  input  logic               clk,
  input  logic               rst,
  input  gme_pkg::rec_t      rec,
  input  logic [1:0]         mode,
  input  logic               put_ok,
  output gme_pkg::mix_stat_t stat,
  output gme_pkg::out_t      res
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TDIV = 8'b0000_0010,
    S_A2   = 8'b0000_0100,
    S_POLY = 8'b0000_1000,
    S_MSTP = 8'b0001_0000,
    S_MULL = 8'b0010_0000,
    S_MULR = 8'b0100_0000,
    S_CDIV = 8'b1000_0000
  } state_t;

  localparam logic [31:0] Q30_ONE = 32'd1073741824;

  state_t         state;
  logic           put;
  gme_pkg::rgba_t lcol;
  gme_pkg::rgba_t rcol;
  gme_pkg::rgba_t outc;
  logic [15:0]    d;
  logic           lin;
  logic           neg;
  logic [16:0]    a;
  logic [16:0]    a2;
  logic [30:0]    h;
  logic [2:0]     k;
  logic [16:0]    wl;
  logic [16:0]    wr;
  logic [1:0]     ch;
  logic [32:0]    acc;
  logic [15:0]    rem;
  logic [16:0]    sh;
  logic [16:0]    quo;
  logic [4:0]     dcnt;

  logic [30:0]    mul_a;
  logic [16:0]    mul_b;
  logic [47:0]    prod;
  logic [16:0]    trial;
  logic           ge;
  logic [15:0]    rem_step;
  logic [16:0]    quo_step;
  logic [17:0]    tq2;
  logic [16:0]    a_new;
  logic [31:0]    m;
  logic [31:0]    mc;
  logic [31:0]    wsum;
  logic [16:0]    w;
  logic [32:0]    acc2;

  always_comb begin
    mul_a = h;
    mul_b = a2;
    case (state)
      S_A2: begin
        mul_a = 31'(a);
        mul_b = a;
      end
      S_MSTP: begin
        mul_a = h;
        mul_b = a;
      end
      S_MULL: begin
        mul_a = 31'(lcol[ch]);
        mul_b = wl;
      end
      S_MULR: begin
        mul_a = 31'(rcol[ch]);
        mul_b = wr;
      end
      default: begin
        mul_a = h;
        mul_b = a2;
      end
    endcase
    prod = 48'(mul_a) * 48'(mul_b);

    trial    = {rem, sh[16]};
    ge       = trial >= {1'b0, d};
    rem_step = ge ? 16'(trial - {1'b0, d}) : trial[15:0];
    quo_step = {quo[15:0], ge};

    tq2   = {quo_step, 1'b0};
    a_new = (quo_step < 17'd32768) ? 17'(18'd65536 - tq2) : 17'(tq2 - 18'd65536);

    m    = prod[47:16];
    mc   = (m > Q30_ONE) ? Q30_ONE : m;
    wsum = neg ? (Q30_ONE - mc + 32'd16384) : (Q30_ONE + mc + 32'd16384);
    w    = wsum[31:15];

    acc2 = acc + prod[32:0] + (lin ? 33'(d >> 1) : 33'd32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      put   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (put) begin
            if (put_ok) put <= 1'b0;
          end else if (rec.vld) begin
            lcol <= rec.lcol;
            rcol <= rec.rcol;
            d    <= 16'(rec.rpos - rec.lpos);
            lin  <= (mode == gme_pkg::MODE_LINEAR);
            ch   <= 2'd0;
            if (!rec.lv && !rec.rv) begin
              // no active stops: opaque black
              outc <= {16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
              put  <= 1'b1;
            end else if (!rec.lv) begin
              outc <= rec.rcol;
              put  <= 1'b1;
            end else if (!rec.rv || (rec.rpos <= rec.lpos) ||
                         (mode == gme_pkg::MODE_CONST)) begin
              outc <= rec.lcol;
              put  <= 1'b1;
            end else if (mode == gme_pkg::MODE_LINEAR) begin
              wl    <= 17'(16'(rec.rpos - rec.x));
              wr    <= 17'(16'(rec.x - rec.lpos));
              state <= S_MULL;
            end else begin
              // t = n * 2^16 / d, 17 quotient bits
              rem   <= 16'(16'(rec.x - rec.lpos) >> 1);
              sh    <= {rec.x[0] ^ rec.lpos[0], 16'd0};
              quo   <= 17'd0;
              dcnt  <= 5'd17;
              state <= S_TDIV;
            end
          end
        end
        S_TDIV: begin
          rem  <= rem_step;
          sh   <= {sh[15:0], 1'b0};
          quo  <= quo_step;
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) begin
            neg   <= quo_step < 17'd32768;
            a     <= a_new;
            state <= S_A2;
          end
        end
        S_A2: begin
          a2    <= prod[32:16];
          h     <= gme_pkg::sin_coef(3'd5);
          k     <= 3'd4;
          state <= S_POLY;
        end
        S_POLY: begin
          h <= 31'(gme_pkg::sin_coef(k) - prod[46:16]);
          if (k == 3'd0) begin
            state <= S_MSTP;
          end else begin
            k <= k - 3'd1;
          end
        end
        S_MSTP: begin
          wl    <= 17'(18'd65536 - 18'(w));
          wr    <= w;
          state <= S_MULL;
        end
        S_MULL: begin
          acc   <= prod[32:0];
          state <= S_MULR;
        end
        S_MULR: begin
          if (lin) begin
            rem   <= acc2[31:16];
            sh    <= {acc2[15:0], 1'b0};
            quo   <= 17'd0;
            dcnt  <= 5'd16;
            state <= S_CDIV;
          end else begin
            outc[ch] <= acc2[31:16];
            if (ch == 2'd3) begin
              put   <= 1'b1;
              state <= S_IDLE;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_MULL;
            end
          end
        end
        S_CDIV: begin
          rem  <= rem_step;
          sh   <= {sh[15:0], 1'b0};
          quo  <= quo_step;
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) begin
            outc[ch] <= quo_step[15:0];
            if (ch == 2'd3) begin
              put   <= 1'b1;
              state <= S_IDLE;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_MULL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle      = (state == S_IDLE) && !put;
  assign stat.res_valid = put;
  assign res.red_out    = outc[0];
  assign res.green_out  = outc[1];
  assign res.blue_out   = outc[2];
  assign res.alpha_out  = outc[3];

endmodule

@@ rtl/gradient_map_evaluate_top.sv @@
// Gradient map evaluator top: config registers, row of stop cells, mixer, output word.
// Depends on gme_pkg, gme_cell and gme_mix.
//
//   channel | direction | handshake           | word
//   in      | input     | in_valid / in_stall | gme_pkg::in_t
//   out     | output    | out_valid/out_stall | gme_pkg::out_t
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A write word goes straight to its stop cell. An evaluate word walks the 16 cells,
// one per cycle, then the mixer: single-stop cases pass directly, linear weights and
// divides per channel, smooth and cubic find a sine-series weight and mix per channel.
// in_stall is high while an evaluate word is in the cells or mixer.
// A finished word waits in the output register while the next word enters.
// Reset sets linear mode, no active stops and clears the valids; the stop table is unknown until written.
module gradient_map_evaluate_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  gme_pkg::in_t  in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output gme_pkg::out_t out_word,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [4:0]    cfg_data
);

  logic [1:0]                  interp_mode;
  logic [4:0]                  active_stops;
  logic [gme_pkg::CNT_W-1:0]   cnt;
  logic                        busy;
  logic                        acc_in;
  logic                        put_ok;
  gme_pkg::wr_t                wr;
  gme_pkg::rec_t               head;
  gme_pkg::rec_t               link [gme_pkg::MAX_STOPS+1];
  logic [gme_pkg::MAX_STOPS:0] vbits;
  gme_pkg::mix_stat_t          mstat;
  gme_pkg::out_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode  <= gme_pkg::MODE_LINEAR;
      active_stops <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        gme_pkg::CFG_INTERP_MODE:  interp_mode  <= cfg_data[1:0];
        gme_pkg::CFG_ACTIVE_STOPS: active_stops <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cnt = (32'(active_stops) > gme_pkg::MAX_STOPS) ?
               gme_pkg::CNT_W'(gme_pkg::MAX_STOPS) : gme_pkg::CNT_W'(active_stops);

  assign in_stall = busy;
  assign acc_in   = in_valid && !in_stall;

  always_comb begin
    wr.en   = acc_in && (in_word.req_type == gme_pkg::REQ_WRITE);
    wr.slot = in_word.stop_slot;
    wr.pos  = in_word.coord[gme_pkg::COORD_BITS-1:0];
    wr.col  = {in_word.alpha_in, in_word.blue_in, in_word.green_in, in_word.red_in};

    head      = '0;
    head.vld  = acc_in && (in_word.req_type == gme_pkg::REQ_EVAL);
    head.x    = in_word.coord[gme_pkg::COORD_BITS-1:0];
  end

  assign link[0] = head;

  for (genvar g = 0; g < gme_pkg::MAX_STOPS; g++) begin : g_cell
    gme_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_idx(gme_pkg::SLOT_W'(g)),
      .cnt     (cnt),
      .wr      (wr),
      .rec_in  (link[g]),
      .rec_out (link[g+1])
    );
  end

  for (genvar g = 0; g <= gme_pkg::MAX_STOPS; g++) begin : g_vbit
    assign vbits[g] = link[g].vld;
  end

  gme_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .rec   (link[gme_pkg::MAX_STOPS]),
    .mode  (interp_mode),
    .put_ok(put_ok),
    .stat  (mstat),
    .res   (res)
  );

  assign put_ok = mstat.res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (head.vld) begin
        busy <= 1'b1;
      end else if (put_ok) begin
        busy <= 1'b0;
      end
      if (put_ok) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put_ok) out_word <= res;
  end

  // one evaluate word in flight at most
  a_one_search: assert property (@(posedge clk) disable iff (rst) $onehot0(vbits))
    else $error("more than one search record in the cell row");

  a_mix_free: assert property (@(posedge clk) disable iff (rst)
    link[gme_pkg::MAX_STOPS].vld |-> mstat.idle)
    else $error("search record reached a busy mixer");

  a_release: assert property (@(posedge clk) disable iff (rst)
    put_ok |=> !busy && out_valid)
    else $error("result handoff did not release the input");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> mstat.idle && (vbits[gme_pkg::MAX_STOPS:1] == '0))
    else $error("work left while input is open");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for gradient_map_evaluate_top: stop table writes, evaluate words,
// every interpolation mode, random idling on both channels. Depends on gme_pkg and the RTL.
module tb;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE       = 200;

  logic          clk, rst;
  logic          in_valid, in_stall;
  gme_pkg::in_t  in_word;
  logic          out_valid, out_stall;
  gme_pkg::out_t out_word;
  logic          cfg_we;
  logic          cfg_index;
  logic [4:0]    cfg_data;

  gradient_map_evaluate_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the stop table and registers
  logic [15:0]    stop_pos [gme_pkg::MAX_STOPS];
  gme_pkg::rgba_t stop_col [gme_pkg::MAX_STOPS];
  logic [1:0]     cur_mode;
  logic [4:0]     cur_count;

  gme_pkg::out_t expected_colors [$];
  int   fail_count;
  int   cycles = 0;
  int   eval_count, write_count, config_count;
  bit   calm;  // no idling on either side while set

  localparam longint unsigned SIN_Q30 [6] = '{
    64'd1686629713, 64'd693598684, 64'd85569306, 64'd5026999, 64'd172272, 64'd3864
  };
  localparam longint unsigned Q30 = 64'd1073741824;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint unsigned cosine_weight(longint unsigned n, longint unsigned d);
    longint unsigned tq, a, a2, h, m;
    bit neg;
    tq  = (n << 16) / d;
    neg = tq < 32768;
    a   = neg ? (65536 - 2 * tq) : (2 * tq - 65536);
    a2  = (a * a) >> 16;
    h   = SIN_Q30[5];
    for (int k = 4; k >= 0; k--) h = SIN_Q30[k] - ((h * a2) >> 16);
    m = (h * a) >> 16;
    if (m > Q30) m = Q30;
    return neg ? ((Q30 - m + 16384) >> 15) : ((Q30 + m + 16384) >> 15);
  endfunction

  function automatic gme_pkg::out_t gradient_color(logic [15:0] x);
    int lo, hi, cnt;
    gme_pkg::rgba_t res;
    longint unsigned d, n, w, cl, cr;
    gme_pkg::out_t o;
    lo  = -1;
    hi  = -1;
    cnt = (cur_count < gme_pkg::MAX_STOPS) ? int'(cur_count) : gme_pkg::MAX_STOPS;
    if (cnt == 0) begin
      res = '0;
      res[3] = 16'hFFFF;
    end else begin
      for (int i = 0; i < cnt; i++) begin
        if (stop_pos[i] <= x && (lo < 0 || stop_pos[i] > stop_pos[lo])) lo = i;
        if (stop_pos[i] >= x && (hi < 0 || stop_pos[i] < stop_pos[hi])) hi = i;
      end
      if (lo < 0) begin
        res = stop_col[hi];
      end else if (hi < 0 || lo == hi || stop_pos[hi] <= stop_pos[lo] ||
                   cur_mode == gme_pkg::MODE_CONST) begin
        res = stop_col[lo];
      end else begin
        d = stop_pos[hi] - stop_pos[lo];
        n = x - stop_pos[lo];
        w = cosine_weight(n, d);
        for (int c = 0; c < 4; c++) begin
          cl = stop_col[lo][c];
          cr = stop_col[hi][c];
          if (cur_mode == gme_pkg::MODE_LINEAR) begin
            res[c] = 16'((cl * (d - n) + cr * n + d / 2) / d);
          end else begin
            res[c] = 16'((cl * (65536 - w) + cr * w + 32768) >> 16);
          end
        end
      end
    end
    o.red_out   = res[0];
    o.green_out = res[1];
    o.blue_out  = res[2];
    o.alpha_out = res[3];
    return o;
  endfunction

  // send one word, then update the local table or queue the expected color
  task automatic send_word(gme_pkg::in_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (w.req_type == gme_pkg::REQ_WRITE) begin
      stop_pos[w.stop_slot] = w.coord;
      stop_col[w.stop_slot] = {w.alpha_in, w.blue_in, w.green_in, w.red_in};
      write_count++;
    end else begin
      expected_colors.insert(expected_colors.size(), gradient_color(w.coord));
      eval_count++;
    end
  endtask

  task automatic write_stop(logic [3:0] slot, logic [15:0] pos);
    gme_pkg::in_t w;
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    w = r[$bits(gme_pkg::in_t)-1:0];
    w.req_type  = gme_pkg::REQ_WRITE;
    w.stop_slot = slot;
    w.coord     = pos;
    send_word(w);
  endtask

  task automatic eval_at(logic [15:0] x);
    gme_pkg::in_t w;
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    w = r[$bits(gme_pkg::in_t)-1:0];
    w.req_type = gme_pkg::REQ_EVAL;
    w.coord    = x;
    send_word(w);
  endtask

  // drop the input valid, then wait until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_reg(logic idx, logic [4:0] val);
    wait_drained();
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == gme_pkg::CFG_INTERP_MODE) cur_mode = val[1:0];
    else cur_count = val;
    config_count++;
  endtask

  // result checker
  initial begin
    int n;
    gme_pkg::out_t e;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = calm ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_colors.size() == 0) begin
        $error("unexpected result word %h", out_word);
        fail_count++;
      end else begin
        e = expected_colors.pop_front();
        if (out_word.red_out !== e.red_out) begin
          $error("red_out expected %h got %h", e.red_out, out_word.red_out);
          fail_count++;
        end
        if (out_word.green_out !== e.green_out) begin
          $error("green_out expected %h got %h", e.green_out, out_word.green_out);
          fail_count++;
        end
        if (out_word.blue_out !== e.blue_out) begin
          $error("blue_out expected %h got %h", e.blue_out, out_word.blue_out);
          fail_count++;
        end
        if (out_word.alpha_out !== e.alpha_out) begin
          $error("alpha_out expected %h got %h", e.alpha_out, out_word.alpha_out);
          fail_count++;
        end
      end
    end
  end

  // reset values: linear mode, no stops, so opaque black
  task automatic test_reset_state();
    eval_at(16'h0000);
    eval_at(16'hFFFF);
  endtask

  // fill every slot so no unwritten entry is ever read
  task automatic test_fill_table();
    for (int i = 0; i < gme_pkg::MAX_STOPS; i++) begin
      write_stop(4'(i), (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom));
    end
  endtask

  task automatic test_directed();
    set_reg(gme_pkg::CFG_ACTIVE_STOPS, 5'd1);   // single stop
    eval_at(16'h8000);
    set_reg(gme_pkg::CFG_ACTIVE_STOPS, 5'd31);  // count clamps to table size
    eval_at(16'h0000);
    eval_at(16'hFFFF);
    eval_at(16'h4000);
    write_stop(4'd3, stop_pos[2]);     // tie on position, first index wins
    eval_at(stop_pos[2]);
    for (int m = 0; m < 4; m++) begin
      set_reg(gme_pkg::CFG_INTERP_MODE, 5'(m));
      eval_at(16'h3000);
      eval_at(16'($urandom));
    end
    set_reg(gme_pkg::CFG_ACTIVE_STOPS, 5'd2);
    write_stop(4'd0, 16'h1000);        // left stop missing below 0x1000
    write_stop(4'd1, 16'hF000);        // right stop missing above 0xF000
    eval_at(16'h0000);
    eval_at(16'hFFFF);
    eval_at(16'h8000);
    write_stop(4'd1, 16'h1000);        // coinciding positions
    eval_at(16'h1000);
    set_reg(gme_pkg::CFG_ACTIVE_STOPS, 5'd0);
    eval_at(16'h2222);
  endtask

  task automatic test_random_phases();
    int cnt;
    logic [15:0] x;
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 5);
      set_reg(gme_pkg::CFG_INTERP_MODE, (ph < 4) ? 5'(ph) : 5'($urandom));
      cnt = (ph == 0) ? 16 : (ph == 1) ? 0 : (ph == 2) ? 31 : $urandom_range(1, 20);
      set_reg(gme_pkg::CFG_ACTIVE_STOPS, 5'(cnt));
      for (int k = 0; k < 210; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          // sometimes copy a position to make ties and coincident stops
          if ($urandom_range(0, 3) == 0) write_stop(4'($urandom), stop_pos[$urandom_range(0, 15)]);
          else write_stop(4'($urandom), 16'($urandom));
        end else begin
          case ($urandom_range(0, 5))
            0:       x = stop_pos[$urandom_range(0, 15)];
            1:       x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: x = 16'($urandom);
          endcase
          eval_at(x);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = gme_pkg::CFG_INTERP_MODE;
    cfg_data = '0;
    fail_count = 0;
    eval_count = 0;
    write_count = 0;
    config_count = 0;
    calm = 1'b0;
    cur_mode = gme_pkg::MODE_LINEAR;
    cur_count = '0;
    for (int i = 0; i < gme_pkg::MAX_STOPS; i++) begin
      stop_pos[i] = '0;
      stop_col[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_fill_table();
    test_directed();
    test_random_phases();

    wait_drained();
    $display("Covered %0d evaluates and %0d stop writes over %0d register writes,",
             eval_count, write_count, config_count);
    $display("all four modes and counts from none to beyond the table size.");
    if (fail_count == 0 && expected_colors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gme_pkg.sv
rtl/gme_cell.sv
rtl/gme_mix.sv
rtl/gradient_map_evaluate_top.sv
test/tb.sv
